>>> hw/rtl/gcdlcm_pkg.sv
// Package for the GCD/LCM unit: word types and shared width constants.
`timescale 1ns / 1ps
`default_nettype none

package gcdlcm_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W           = 32;
    localparam int LCM_W             = 63;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_value;
        logic signed [FIELD_W-1:0] second_value;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0] gcd_out;
        logic [LCM_W-1:0]   lcm_out;
    } t_out_word;

endpackage

`default_nettype wire

>>> hw/rtl/gcd_lcm_unit.sv
// GCD and LCM of two signed operands on one shared adder under a small sequencer.
//
// Usage: present an input word on i_item and raise start while busy is low; the
// word is taken at that clock edge and busy goes high on the next cycle. Each
// operand is the low OPERAND_WIDTH bits of its field, taken as two's complement, and is
// replaced by its magnitude (the most negative value keeps its exact magnitude).
// Exactly one output word follows: o_done is high for a single cycle while
// o_result holds the GCD and the LCM, and busy is low again in that same cycle.
// The receiver cannot stall the block; it must take the word while o_done is high.
//
// Sequence: a binary GCD loop shifts, subtracts or swaps the magnitudes until one
// of them is zero; the GCD is then restored by shifting back the common factors of
// two, the first magnitude is divided by it one quotient bit per cycle, and the
// quotient times the second magnitude is formed by shift-and-add over the quotient
// bits. The GCD, divide and multiply phases share the same 2*OPERAND_WIDTH-bit
// adder. The next word can be taken in the o_done cycle. One word is in flight at
// a time. Reset (synchronous, active low) returns the sequencer to idle and drops
// o_done; no stored data needs clearing.
`timescale 1ns / 1ps
`default_nettype none

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire gcdlcm_pkg::t_in_word  i_item,
    output logic                       o_done,
    output gcdlcm_pkg::t_out_word      o_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * W;
    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;

    logic [2:0]    r_state;
    logic [W-1:0]  r_u;
    logic [W-1:0]  r_v;
    logic [KW-1:0] r_k;
    logic [W-1:0]  r_ma;
    logic [W-1:0]  r_mb;
    logic [W-1:0]  r_g;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_quo;
    logic [DW-1:0] r_mcand;
    logic [DW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    gcdlcm_pkg::t_out_word r_result;

    logic [W-1:0]  w_raw_a;
    logic [W-1:0]  w_raw_b;
    logic [W-1:0]  w_mag_a;
    logic [W-1:0]  w_mag_b;
    logic [W:0]    w_shifted;
    logic [DW-1:0] w_op_a;
    logic [DW-1:0] w_op_b;
    logic          w_sub;
    logic [DW:0]   w_sum;
    logic          w_ge;
    logic          w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    assign w_raw_a = i_item.first_value[W-1:0];
    assign w_raw_b = i_item.second_value[W-1:0];
    assign w_mag_a = w_raw_a[W-1] ? W'(~w_raw_a + W'(1)) : w_raw_a;
    assign w_mag_b = w_raw_b[W-1] ? W'(~w_raw_b + W'(1)) : w_raw_b;

    // Partial remainder with the next dividend bit brought in.
    assign w_shifted = {r_rem[W-1:0], r_quo[W-1]};

    // The shared adder: compare/subtract for GCD and division, add for the product.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        w_sub  = 1'b0;
        unique case (r_state)
            S_GCD: begin
                w_op_a = DW'(r_u);
                w_op_b = DW'(r_v);
                w_sub  = 1'b1;
            end
            S_DIV: begin
                w_op_a = DW'(w_shifted);
                w_op_b = DW'(r_g);
                w_sub  = 1'b1;
            end
            S_MUL: begin
                w_op_a = r_acc;
                w_op_b = r_mcand;
                w_sub  = 1'b0;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum = {1'b0, w_op_a} + {1'b0, (w_sub ? ~w_op_b : w_op_b)} + (DW + 1)'(w_sub);
    // On a subtract, the carry out is set when the first operand is not below the second.
    assign w_ge  = w_sum[DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ma    <= w_mag_a;
                        r_mb    <= w_mag_b;
                        r_u     <= w_mag_a;
                        r_v     <= w_mag_b;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    // Binary GCD: strip common factors of two, then subtract odd values.
                    priority if (r_u == '0) begin
                        r_u     <= r_v;
                        r_state <= S_FIN;
                    end else if (r_v == '0) begin
                        r_state <= S_FIN;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (w_ge) begin
                        r_u <= w_sum[W-1:0];
                    end else begin
                        r_u <= r_v;
                        r_v <= r_u;
                    end
                end
                S_FIN: begin
                    r_g <= r_u << r_k;
                    if (r_u == '0) begin
                        r_result.gcd_out <= '0;
                        r_result.lcm_out <= '0;
                        r_done           <= 1'b1;
                        r_state          <= S_IDLE;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= r_ma;
                        r_cnt   <= CW'(W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= w_sum[W:0];
                        r_quo <= {r_quo[W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_shifted;
                        r_quo <= {r_quo[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_acc   <= '0;
                        r_mcand <= DW'(r_mb);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_quo == '0) begin
                        r_result.gcd_out <= gcdlcm_pkg::FIELD_W'(r_g);
                        r_result.lcm_out <= gcdlcm_pkg::LCM_W'(r_acc);
                        r_done           <= 1'b1;
                        r_state          <= S_IDLE;
                    end else begin
                        if (r_quo[0]) begin
                            r_acc <= w_sum[DW-1:0];
                        end
                        r_mcand <= r_mcand << 1;
                        r_quo   <= r_quo >> 1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A word is only delivered at the end of a run.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result word without a run in progress");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted word did not start a run");

    a_lcm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.gcd_out == '0)) |-> (o_result.lcm_out == '0))
        else $error("nonzero LCM with zero GCD");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < (W + 1)'(r_g)))
        else $error("partial remainder not below the divisor");

endmodule

`default_nettype wire

>>> dv/gcd_lcm_unit_tb.sv
// Self-checking testbench for the GCD/LCM unit: directed table, random operand pairs.
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;

    localparam int OP_W          = gcdlcm_pkg::OPERAND_WIDTH_DEF;
    localparam int RANDOM_WORDS  = 1525;
    localparam int CALM_TAIL     = 200;
    localparam int DRAIN_CYCLES  = 300;
    localparam int DIRECTED_ROWS = 23;

    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        bit          typed;
        logic [31:0] gcd;
        logic [62:0] lcm;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    gcdlcm_pkg::t_in_word  i_item;
    logic                  o_done;
    gcdlcm_pkg::t_out_word o_result;

    gcdlcm_pkg::t_out_word pending_results[$];
    gcdlcm_pkg::t_out_word expected_word;
    t_dir_row              directed_rows [DIRECTED_ROWS];
    int                    fail_count = 0;

    gcd_lcm_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Magnitude of the low OP_W bits taken as two's complement; the most negative
    // value keeps its full magnitude because the arithmetic is 64 bits wide.
    function automatic logic [63:0] operand_magnitude(input logic [31:0] field);
        logic [63:0] mask;
        logic [63:0] raw;
        mask = (64'd1 << OP_W) - 64'd1;
        raw  = {32'd0, field} & mask;
        if (raw[OP_W-1]) begin
            return (~raw + 64'd1) & mask;
        end
        return raw;
    endfunction

    function automatic gcdlcm_pkg::t_out_word gcd_lcm_of(input gcdlcm_pkg::t_in_word w);
        logic [63:0]           ma;
        logic [63:0]           mb;
        logic [63:0]           x;
        logic [63:0]           y;
        logic [63:0]           t;
        logic [63:0]           multiple;
        gcdlcm_pkg::t_out_word res;
        ma = operand_magnitude(w.first_value);
        mb = operand_magnitude(w.second_value);
        x  = ma;
        y  = mb;
        while (y != 64'd0) begin
            t = y;
            y = x % y;
            x = t;
        end
        multiple = (x != 64'd0) ? (ma * mb) / x : 64'd0;
        res.gcd_out = x[31:0];
        res.lcm_out = multiple[62:0];
        return res;
    endfunction

    function automatic logic [31:0] apply_sign(input logic [31:0] mag, input bit negative);
        return negative ? -mag : mag;
    endfunction

    function automatic gcdlcm_pkg::t_in_word random_operands();
        gcdlcm_pkg::t_in_word w;
        logic [31:0]          factor;
        int                   kind;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            w.first_value  = $urandom;
            w.second_value = $urandom;
        end else if (kind < 60) begin
            // Shared factor so that the GCD is rarely 1.
            factor         = $urandom_range(1, 65535);
            w.first_value  = apply_sign(factor * $urandom_range(0, 32767), $urandom_range(0, 1));
            w.second_value = apply_sign(factor * $urandom_range(0, 32767), $urandom_range(0, 1));
        end else if (kind < 70) begin
            w.first_value  = $urandom_range(0, 1) ? 32'd0 : $urandom;
            w.second_value = $urandom_range(0, 1) ? 32'd0 : apply_sign($urandom_range(0, 9),
                                                                        $urandom_range(0, 1));
        end else if (kind < 80) begin
            case ($urandom_range(0, 3))
                0:       w.first_value = S_MIN;
                1:       w.first_value = S_MAX;
                default: w.first_value = apply_sign(32'd1 << $urandom_range(0, 30),
                                                    $urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 3))
                0:       w.second_value = S_MIN;
                1:       w.second_value = $urandom;
                default: w.second_value = apply_sign(32'd1 << $urandom_range(0, 30),
                                                     $urandom_range(0, 1));
            endcase
        end else if (kind < 90) begin
            factor         = $urandom;
            w.first_value  = factor;
            w.second_value = apply_sign(factor * $urandom_range(1, 3), $urandom_range(0, 1));
        end else begin
            w.first_value  = apply_sign($urandom_range(0, 1000), $urandom_range(0, 1));
            w.second_value = apply_sign($urandom_range(0, 1000), $urandom_range(0, 1));
        end
        if ($urandom_range(0, 1)) begin
            factor         = w.first_value;
            w.first_value  = w.second_value;
            w.second_value = factor;
        end
        return w;
    endfunction

    // Drives one word and records its expected result once the block takes it.
    task automatic send_word(input gcdlcm_pkg::t_in_word w, input bit typed,
                             input gcdlcm_pkg::t_out_word typed_res, input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            start <= 1'b0;
            // Idle cycles only count once the block is ready again.
            while (busy) @(negedge i_clk);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(typed ? typed_res : gcd_lcm_of(w));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result word with none expected: gcd_out %0d lcm_out %0d",
                       o_result.gcd_out, o_result.lcm_out);
                fail_count++;
            end else begin
                expected_word = pending_results.pop_front();
                if (o_result.gcd_out !== expected_word.gcd_out) begin
                    $error("gcd_out: expected %0d, got %0d",
                           expected_word.gcd_out, o_result.gcd_out);
                    fail_count++;
                end
                if (o_result.lcm_out !== expected_word.lcm_out) begin
                    $error("lcm_out: expected %0d, got %0d",
                           expected_word.lcm_out, o_result.lcm_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        gcdlcm_pkg::t_in_word  w;
        gcdlcm_pkg::t_out_word typed_res;
        bit                    gaps_on;

        directed_rows = '{
            '{32'd0,         32'd0,          1'b1, 32'd0,         63'd0},
            '{32'd0,         32'd5,          1'b1, 32'd5,         63'd0},
            '{-32'sd7,       32'd0,          1'b1, 32'd7,         63'd0},
            '{S_MIN,         32'd0,          1'b1, 32'h8000_0000, 63'd0},
            '{32'd0,         S_MIN,          1'b1, 32'h8000_0000, 63'd0},
            '{S_MIN,         S_MIN,          1'b1, 32'h8000_0000, 63'h8000_0000},
            '{S_MAX,         S_MAX,          1'b1, 32'h7FFF_FFFF, 63'h7FFF_FFFF},
            '{32'd1,         32'd1,          1'b1, 32'd1,         63'd1},
            '{-32'sd1,       -32'sd1,        1'b1, 32'd1,         63'd1},
            '{S_MIN,         32'd1,          1'b1, 32'd1,         63'h8000_0000},
            '{S_MIN,         -32'sd1,        1'b1, 32'd1,         63'h8000_0000},
            '{S_MAX,         32'd1,          1'b1, 32'd1,         63'h7FFF_FFFF},
            '{S_MAX,         32'd0,          1'b1, 32'h7FFF_FFFF, 63'd0},
            '{-32'sd12,      32'd18,         1'b1, 32'd6,         63'd36},
            '{S_MIN,         S_MAX,          1'b0, 32'd0,         63'd0},
            '{S_MAX,         32'h7FFF_FFFE,  1'b0, 32'd0,         63'd0},
            '{32'd1836311903, 32'd1134903170, 1'b0, 32'd0,        63'd0},
            '{-32'sd1134903170, 32'd701408733, 1'b0, 32'd0,       63'd0},
            '{32'h4000_0000, -32'sh0010_0000, 1'b0, 32'd0,        63'd0},
            '{S_MIN,         32'h4000_0000,  1'b0, 32'd0,         63'd0},
            '{-32'sh7FFF_FFFF, S_MIN,        1'b0, 32'd0,         63'd0},
            '{32'hAAAA_AAAA, 32'h5555_5555,  1'b0, 32'd0,         63'd0},
            '{32'h0003_0000, 32'h0005_0000,  1'b0, 32'd0,         63'd0}
        };

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            w.first_value     = directed_rows[i].a;
            w.second_value    = directed_rows[i].b;
            typed_res.gcd_out = directed_rows[i].gcd;
            typed_res.lcm_out = directed_rows[i].lcm;
            send_word(w, directed_rows[i].typed, typed_res, 1'b1);
        end

        // Idle bursts come in stretches, with quiet stretches between and none at the end.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gaps_on = (n < RANDOM_WORDS - CALM_TAIL) && ((n / 40) % 3 != 2);
            send_word(random_operands(), 1'b0, '0, gaps_on);
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/gcdlcm_pkg.sv
hw/rtl/gcd_lcm_unit.sv
dv/gcd_lcm_unit_tb.sv
